### design/string_intern_hash_dictionary_unit_macros.svh
// Assertion macros for the string interning dictionary.
// Used by sihd_table and the top level.
`ifndef STRING_INTERN_HASH_DICTIONARY_UNIT_MACROS_SVH
`define STRING_INTERN_HASH_DICTIONARY_UNIT_MACROS_SVH
// implication checked every clock outside reset
`define SIHD_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("sihd check failed");
// next-cycle implication checked every clock outside reset
`define SIHD_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("sihd check failed");
`endif

### design/sihd_pkg.sv
// Shared constants and types for the string interning dictionary.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sihd_pkg;
    localparam int SLOT_COUNT_D   = 4096;
    localparam int BUFFER_BYTES_D = 65536;
    localparam int MAX_ENTRIES_D  = 2048;
    localparam logic [31:0] HASH_SEED = 32'd5381;

    typedef enum logic [2:0] {
        ST_FOUND        = 3'd0,
        ST_ADDED        = 3'd1,
        ST_MISSING      = 3'd2,
        ST_ENTRIES_FULL = 3'd3,
        ST_BUFFER_FULL  = 3'd4
    } t_status;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_ADD    = 1'b1;

    function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [7:0] c);
        logic [31:0] ext;
        ext = {{24{c[7]}}, c};
        return ((h << 5) + h) ^ ext;
    endfunction
endpackage
`default_nettype wire

### design/sihd_table.sv
// Slot table with reset-clearing sweep for the string interning dictionary.
// Depends on sihd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sihd_table
    import sihd_pkg::*;
#(
    parameter int SLOT_COUNT  = SLOT_COUNT_D,
    parameter int MAX_ENTRIES = MAX_ENTRIES_D
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire [$clog2(SLOT_COUNT)-1:0]  i_rd_addr,
    input  wire                           i_wr_en,
    input  wire [$clog2(SLOT_COUNT)-1:0]  i_wr_addr,
    input  wire [$clog2(MAX_ENTRIES)-1:0] i_wr_entry,
    output logic                          o_rd_valid,
    output logic [$clog2(MAX_ENTRIES)-1:0] o_rd_entry,
    output logic                          o_ready
);
    `include "string_intern_hash_dictionary_unit_macros.svh"
    localparam int SW = $clog2(SLOT_COUNT);
    localparam int EW = $clog2(MAX_ENTRIES);

    logic [EW:0] mem [SLOT_COUNT];
    logic [SW:0] r_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (!r_clr[SW]) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    assign o_ready = r_clr[SW];

    always_ff @(posedge i_clk) begin
        if (!r_clr[SW]) begin
            mem[r_clr[SW-1:0]] <= '0;
        end else if (i_wr_en) begin
            mem[i_wr_addr] <= {1'b1, i_wr_entry};
        end
        {o_rd_valid, o_rd_entry} <= mem[i_rd_addr];
    end

    `SIHD_ASSERT_IMP(a_no_write_in_clear, i_clk, i_rst_n, !o_ready, !i_wr_en)
    `SIHD_ASSERT_NXT(a_ready_stays, i_clk, i_rst_n, o_ready, o_ready)
endmodule
`default_nettype wire

### design/string_intern_hash_dictionary_unit.sv
// String interning dictionary: one character byte per start pulse, one result per terminator.
// After reset a clearing sweep of every slot runs with busy high. Non-zero bytes are hashed
// and stored while idle. A terminating byte holds busy while the slot table and entry memories
// are probed slot by slot (S_SLOT_RD, S_SLOT_WAIT, S_ENT_CHK) and each matching-hash candidate
// is compared byte by byte (S_CMP_RD, S_CMP_CHK) against the string store. The result appears
// on o_strobe for one cycle and cannot be stalled. Depends on sihd_pkg and sihd_table.
`timescale 1ns / 1ps
`default_nettype none
module string_intern_hash_dictionary_unit
    import sihd_pkg::*;
#(
    parameter int SLOT_COUNT   = SLOT_COUNT_D,
    parameter int BUFFER_BYTES = BUFFER_BYTES_D,
    parameter int MAX_ENTRIES  = MAX_ENTRIES_D
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire         i_opcode,
    input  wire  [7:0]  i_char_byte,
    output logic        o_strobe,
    output logic [10:0] o_entry_index,
    output logic [15:0] o_string_offset,
    output logic [2:0]  o_status
);
    `include "string_intern_hash_dictionary_unit_macros.svh"
    localparam int SW = $clog2(SLOT_COUNT);
    localparam int EW = $clog2(MAX_ENTRIES);
    localparam int BW = $clog2(BUFFER_BYTES);
    localparam int LW = BW + 2;
    localparam logic [LW-1:0] BUF_N = LW'(BUFFER_BYTES);

    typedef enum logic [3:0] {
        S_IDLE, S_SLOT_RD, S_SLOT_WAIT, S_ENT_CHK, S_CMP_RD, S_CMP_CHK, S_ADD, S_OUT
    } t_state;

    logic [7:0]  store [BUFFER_BYTES];
    logic [31:0] ehash [MAX_ENTRIES];
    logic [BW-1:0] eoff [MAX_ENTRIES];

    t_state        r_state;
    logic [31:0]   r_hash;
    logic [LW-1:0] r_len, r_free, r_k;
    logic [EW:0]   r_count;
    logic [SW-1:0] r_slot;
    logic [SW:0]   r_probes;
    logic          r_op;
    logic [EW-1:0] r_e;
    logic [31:0]   r_eh;
    logic [BW-1:0] r_eo;
    logic [7:0]    r_ba, r_bb;
    logic [LW-1:0] r_pa, r_pb;
    logic          r_pa_ok, r_pb_ok;

    logic          tb_valid, tb_ready;
    logic [EW-1:0] tb_entry;
    logic          tb_wr;

    logic accept;
    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE) || !tb_ready;
    assign tb_wr  = (r_state == S_ADD);

    sihd_table #(.SLOT_COUNT(SLOT_COUNT), .MAX_ENTRIES(MAX_ENTRIES)) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (r_slot),
        .i_wr_en   (tb_wr),
        .i_wr_addr (r_slot),
        .i_wr_entry(r_count[EW-1:0]),
        .o_rd_valid(tb_valid),
        .o_rd_entry(tb_entry),
        .o_ready   (tb_ready)
    );

    logic [LW-1:0] wr_addr;
    logic          wr_en;
    logic [7:0]    wr_data;
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_free + r_len;
        wr_data = i_char_byte;
        if (accept && i_char_byte != 8'd0 && r_len <= BUF_N && wr_addr < BUF_N) begin
            wr_en = 1'b1;
        end
        if (r_state == S_ADD) begin
            wr_en   = 1'b1;
            wr_data = 8'd0;
        end
    end

    // store: one write port, two read ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            store[wr_addr[BW-1:0]] <= wr_data;
        end
        r_ba <= store[r_pa[BW-1:0]];
        r_bb <= store[r_pb[BW-1:0]];
        r_pa_ok <= r_pa < BUF_N;
        r_pb_ok <= r_pb < BUF_N;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ADD) begin
            ehash[r_count[EW-1:0]] <= r_hash;
            eoff[r_count[EW-1:0]]  <= r_free[BW-1:0];
        end
        r_eh <= ehash[tb_entry];
        r_eo <= eoff[tb_entry];
    end

    logic [LW-1:0] new_free;
    assign new_free = r_free + r_len + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_hash   <= HASH_SEED;
            r_len    <= '0;
            r_free   <= '0;
            r_count  <= '0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_char_byte != 8'd0) begin
                            r_hash <= hash_step(r_hash, i_char_byte);
                            if (r_len <= BUF_N) r_len <= r_len + 1'b1;
                        end else begin
                            r_op         <= i_opcode;
                            r_slot       <= r_hash[SW-1:0];
                            r_probes     <= '0;
                            if (r_free + r_len > BUF_N) begin
                                o_status <= ST_BUFFER_FULL;
                                r_state  <= S_OUT;
                            end else begin
                                r_state <= S_SLOT_RD;
                            end
                        end
                    end
                end
                S_SLOT_RD: begin
                    if (r_probes[SW]) begin
                        o_entry_index   <= '0;
                        o_string_offset <= '0;
                        o_status        <= (r_op == OP_LOOKUP) ? ST_MISSING : ST_ENTRIES_FULL;
                        r_state         <= S_OUT;
                    end else begin
                        r_state <= S_SLOT_WAIT;
                    end
                end
                S_SLOT_WAIT: begin
                    if (!tb_valid) begin
                        o_entry_index   <= '0;
                        o_string_offset <= '0;
                        if (r_op == OP_LOOKUP) begin
                            o_status <= ST_MISSING;
                            r_state  <= S_OUT;
                        end else if (r_count >= (EW+1)'(MAX_ENTRIES)) begin
                            o_status <= ST_ENTRIES_FULL;
                            r_state  <= S_OUT;
                        end else if (new_free > BUF_N) begin
                            o_status <= ST_BUFFER_FULL;
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_ADD;
                        end
                    end else begin
                        r_e     <= tb_entry;
                        r_state <= S_ENT_CHK;
                    end
                end
                S_ENT_CHK: begin
                    if ({1'b0, r_e} < r_count && r_eh == r_hash) begin
                        r_k     <= '0;
                        r_pa    <= LW'(r_eo);
                        r_pb    <= r_free;
                        r_state <= S_CMP_RD;
                    end else begin
                        r_slot   <= r_slot + 1'b1;
                        r_probes <= r_probes + 1'b1;
                        r_state  <= S_SLOT_RD;
                    end
                end
                S_CMP_RD: r_state <= S_CMP_CHK;
                S_CMP_CHK: begin
                    if (r_k == r_len) begin
                        if (r_pa_ok && r_ba == 8'd0) begin
                            o_entry_index   <= 11'(r_e);
                            o_string_offset <= 16'(r_eo);
                            o_status        <= ST_FOUND;
                            r_state         <= S_OUT;
                        end else begin
                            r_slot   <= r_slot + 1'b1;
                            r_probes <= r_probes + 1'b1;
                            r_state  <= S_SLOT_RD;
                        end
                    end else if ((r_pa_ok ? r_ba : 8'd0) != (r_pb_ok ? r_bb : 8'd0)) begin
                        r_slot   <= r_slot + 1'b1;
                        r_probes <= r_probes + 1'b1;
                        r_state  <= S_SLOT_RD;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_pa    <= r_pa + 1'b1;
                        r_pb    <= r_pb + 1'b1;
                        r_state <= S_CMP_RD;
                    end
                end
                S_ADD: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    o_strobe <= 1'b1;
                    r_hash   <= HASH_SEED;
                    r_len    <= '0;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_IDLE && accept && i_char_byte == 8'd0) begin
                o_entry_index   <= '0;
                o_string_offset <= '0;
            end
            if (r_state == S_ADD) begin
                o_entry_index   <= 11'(r_count);
                o_string_offset <= 16'(r_free);
                o_status        <= ST_ADDED;
                r_count         <= r_count + 1'b1;
                r_free          <= new_free;
            end
        end
    end

    `SIHD_ASSERT_NXT(a_strobe_one_cycle, i_clk, i_rst_n, o_strobe, !o_strobe)
    `SIHD_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, o_strobe, r_state == S_IDLE)
    `SIHD_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= (EW+1)'(MAX_ENTRIES))
endmodule
`default_nettype wire
